>>> rtl/sjkr_pkg.sv
// Shared types and constants of the Shift-JIS / kuten font ROM address mapper.
`timescale 1ns / 1ps

package sjkr_pkg;

  // Field widths
  localparam int unsigned AddrW = 18;
  localparam int unsigned CodeW = 16;

  // Kuten cells per row; one Shift-JIS lead byte spans two rows
  localparam logic [7:0] CellsPerRow = 8'd94;

  // Font ROM region bases
  localparam logic [AddrW-1:0] BaseRow1  = 18'h00000;
  localparam logic [AddrW-1:0] BaseRow16 = 18'h0AA40;
  localparam logic [AddrW-1:0] BaseRow48 = 18'h21CE0;
  localparam logic [AddrW-1:0] BaseRow85 = 18'h3C4A0;
  localparam logic [AddrW-1:0] BaseRow88 = 18'h3D060;
  localparam logic [AddrW-1:0] BaseAscii = 18'h3E7E0;
  localparam logic [AddrW-1:0] BaseKana  = 18'h3E060;

  // Input function codes
  localparam logic FuncKuten = 1'b0;
  localparam logic FuncSjis  = 1'b1;

  // One result beat
  typedef struct packed {
    logic [AddrW-1:0] rom_address;
    logic [CodeW-1:0] conv_kuten;
    logic             half_width;
    logic             glyph_mapped;
  } sjkr_res_t;

endpackage

>>> rtl/sjkr_map.sv
// Combinational Shift-JIS to kuten conversion and kuten to font ROM address map.
`timescale 1ns / 1ps

module sjkr_map (
  input  logic                        func_i,
  input  logic [sjkr_pkg::CodeW-1:0]  char_code_i,
  output sjkr_pkg::sjkr_res_t         res_o
);

  logic [7:0] lead, trail;
  logic       lead_a, lead_b, trail_a, trail_b, sj_ok;
  logic [7:0] li_full, ti;
  logic [5:0] li;
  logic       ti_hi;
  logic [7:0] sj_row, sj_cell;
  logic [15:0] kuten;

  logic [7:0] row, col;
  logic       cell_ok;
  logic [5:0] row_off;
  logic [7:0] half_off;
  logic [sjkr_pkg::AddrW-1:0] base;
  logic       is_full, is_half;
  logic [11:0] full_idx;
  logic [sjkr_pkg::AddrW-1:0] full_addr, half_addr;

  assign lead  = char_code_i[15:8];
  assign trail = char_code_i[7:0];

  // Shift-JIS byte validity
  assign lead_a  = (lead >= 8'h81) && (lead <= 8'h9F);
  assign lead_b  = (lead >= 8'hE0) && (lead <= 8'hEF);
  assign trail_a = (trail >= 8'h40) && (trail <= 8'h7E);
  assign trail_b = (trail >= 8'h80) && (trail <= 8'hFC);
  assign sj_ok   = (lead_a || lead_b) && (trail_a || trail_b);

  // Lead index 0..46, trail index 0..187
  assign li_full = lead_a ? (lead - 8'h81) : (lead - 8'hC1);
  assign li      = li_full[5:0];
  assign ti      = trail_a ? (trail - 8'h40) : (trail - 8'h41);

  // seq = 188*li + ti: row = 2*li + (ti >= 94) + 1, cell = ti mod 94 + 1
  assign ti_hi   = (ti >= sjkr_pkg::CellsPerRow);
  assign sj_row  = {1'b0, li, 1'b0} + {7'd0, ti_hi} + 8'd1;
  assign sj_cell = ti - (ti_hi ? sjkr_pkg::CellsPerRow : 8'd0) + 8'd1;

  // Kuten code; invalid Shift-JIS becomes 0, which maps to nothing
  always_comb begin
    if (func_i == sjkr_pkg::FuncKuten) begin
      kuten = char_code_i;
    end else if (lead == 8'd0) begin
      kuten = {8'd0, trail};
    end else if (sj_ok) begin
      kuten = {sj_row, sj_cell};
    end else begin
      kuten = 16'd0;
    end
  end

  assign row     = kuten[15:8];
  assign col     = kuten[7:0];
  assign cell_ok = (col >= 8'd1) && (col <= sjkr_pkg::CellsPerRow);

  // Region decode, in priority order
  always_comb begin
    row_off  = 6'd0;
    half_off = 8'd0;
    base     = '0;
    is_full  = 1'b0;
    is_half  = 1'b0;
    if (row >= 8'd1 && row <= 8'd15 && cell_ok) begin
      is_full = 1'b1;
      row_off = 6'(row - 8'd1);
      base    = sjkr_pkg::BaseRow1;
    end else if (row >= 8'd16 && row <= 8'd47 && cell_ok) begin
      is_full = 1'b1;
      row_off = 6'(row - 8'd16);
      base    = sjkr_pkg::BaseRow16;
    end else if (row >= 8'd48 && row <= 8'd84 && cell_ok) begin
      is_full = 1'b1;
      row_off = 6'(row - 8'd48);
      base    = sjkr_pkg::BaseRow48;
    end else if (row == 8'd85 && cell_ok) begin
      is_full = 1'b1;
      row_off = 6'd0;
      base    = sjkr_pkg::BaseRow85;
    end else if (row >= 8'd88 && row <= 8'd89 && cell_ok) begin
      is_full = 1'b1;
      row_off = 6'(row - 8'd88);
      base    = sjkr_pkg::BaseRow88;
    end else if (row == 8'd0 && col >= 8'h20 && col <= 8'h7F) begin
      is_half  = 1'b1;
      half_off = col - 8'h20;
      base     = sjkr_pkg::BaseAscii;
    end else if (row == 8'd0 && col >= 8'hA1 && col <= 8'hDF) begin
      is_half  = 1'b1;
      half_off = col - 8'hA1;
      base     = sjkr_pkg::BaseKana;
    end
  end

  // Glyph index times glyph size plus region base
  assign full_idx  = {6'd0, row_off} * {4'd0, sjkr_pkg::CellsPerRow}
                   + {4'd0, col - 8'd1};
  assign full_addr = {1'b0, full_idx, 5'd0} + base;
  assign half_addr = {6'd0, half_off, 4'd0} + base;

  always_comb begin
    res_o.conv_kuten   = kuten;
    res_o.half_width   = is_half;
    res_o.glyph_mapped = is_full || is_half;
    if (is_full) begin
      res_o.rom_address = full_addr;
    end else if (is_half) begin
      res_o.rom_address = half_addr;
    end else begin
      res_o.rom_address = '0;
    end
  end

endmodule

>>> rtl/sjis_kuten_font_rom_address.sv
// Top level: streaming Shift-JIS / kuten to font ROM address mapper.
// Usage:
//   Input channel s_axis_*: one character code per beat. tdata carries the
//   16-bit code (high byte lead or row, low byte trail or cell); tuser says
//   whether it is kuten (0) or Shift-JIS (1).
//   Output channel m_axis_*: one result beat per input beat, in order.
//   tdata carries the font ROM byte address and the converted kuten code;
//   tuser carries the half-width and mapped flags.
// Path: an accepted beat lands in the input register; its result is then
//   held in the result register, from which it is offered on m_axis_*.
// Throughput: one beat per cycle unless m_axis_tready stalls; conversion and
//   region map sit in one short combinational stage between the two registers.
// Stall: while the result register waits on m_axis_tready the input register
//   still takes one more beat; only when both are full does s_axis_tready drop.
// Reset: rst_ni clears both valid flags; nothing else is held.
// Unmapped codes and invalid Shift-JIS bytes give address 0, mapped flag 0.
`timescale 1ns / 1ps

module sjis_kuten_font_rom_address (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] char_code
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [17:0] rom_address, [33:18] conv_kuten, rest 0
  output logic [1:0]  m_axis_tuser    // [0] half_width, [1] glyph_mapped
);

  logic                in_vld_q;
  logic                in_func_q;
  logic [15:0]         in_code_q;
  logic                out_vld_q;
  sjkr_pkg::sjkr_res_t res_d, res_q;
  logic                out_adv, in_adv;

  // Stage advance
  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser;
      in_code_q <= s_axis_tdata;
    end
  end

  // Conversion and region map
  sjkr_map u_map (
    .func_i      (in_func_q),
    .char_code_i (in_code_q),
    .res_o       (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, res_q.conv_kuten, res_q.rom_address};
  assign m_axis_tuser  = {res_q.glyph_mapped, res_q.half_width};

  // Checks
  a_unmapped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.glyph_mapped) |-> (res_q.rom_address == '0 && !res_q.half_width))
    else $error("unmapped result with nonzero address or half-width flag");

  a_half_mapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.half_width) |-> (res_q.glyph_mapped && res_q.rom_address[3:0] == 4'd0))
    else $error("half-width glyph not mapped or misaligned");

  a_full_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.glyph_mapped && !res_q.half_width) |-> (res_q.rom_address[4:0] == 5'd0))
    else $error("full-width glyph address not 32-byte aligned");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_vld_q || !out_vld_q) |-> s_axis_tready)
    else $error("input stalled with a free stage");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_adv) |=> out_vld_q)
    else $error("beat lost between input and result register");

endmodule
